>>> hw/rtl/b64le_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 line encoder.
package b64le_pkg;

   // Line length limits in four-character groups.
   localparam logic [4:0] MAX_GROUPS = 5'd18;
   localparam logic [4:0] MIN_GROUPS = 5'd1;

   // ASCII codes that the encoder emits besides letters.
   localparam logic [6:0] CODE_NEWLINE = 7'd10;
   localparam logic [6:0] CODE_PAD     = 7'd61;
   localparam logic [6:0] CODE_UPPER_A = 7'd65;
   localparam logic [6:0] CODE_LOWER_A = 7'd97;
   localparam logic [6:0] CODE_DIGIT_0 = 7'd48;
   localparam logic [6:0] CODE_PLUS    = 7'd43;
   localparam logic [6:0] CODE_SLASH   = 7'd47;

   // Input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Output beat.
   typedef struct packed {
      logic [6:0] char_code;
      logic       run_last;
   } rsp_type;

   // One group of work handed from the front end to the back end.
   typedef struct packed {
      logic [23:0] bits;     // group bytes, first byte in the top bits
      logic [1:0]  fill;     // bytes held before the closing byte, 0..2
      logic        newline;  // a newline follows the group
   } job_type;

   // Map a six-bit value to its standard base64 character.
   function automatic logic [6:0] b64_letter(input logic [5:0] sextet);
      logic [6:0] s;
      logic [6:0] code;
      s = {1'b0, sextet};
      if (sextet < 6'd26) begin
         code = CODE_UPPER_A + s;
      end else if (sextet < 6'd52) begin
         code = CODE_LOWER_A + (s - 7'd26);
      end else if (sextet < 6'd62) begin
         code = CODE_DIGIT_0 + (s - 7'd52);
      end else if (sextet == 6'd62) begin
         code = CODE_PLUS;
      end else begin
         code = CODE_SLASH;
      end
      return code;
   endfunction

endpackage

>>> hw/rtl/b64le_front.sv
// Front end: gathers bytes into groups, tracks line position, holds the line register.
module b64le_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64le_pkg::req_type req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_data,
   output logic               push_valid,
   input  logic               push_ready,
   output b64le_pkg::job_type push_job
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  fill_ff, fill_in;
   logic [4:0]  line_done_ff, line_done_in;
   logic [4:0]  gpl_ff, gpl_in;
   logic [4:0]  limit;
   logic [4:0]  done;
   logic        accept;
   logic        closes;

   // Always writable; the user must write it only while idle, unchecked by the block.
   assign csr_ready = 1'b1;
   assign gpl_in    = (csr_valid) ? csr_data : gpl_ff;

   // Clamp the register into the legal range of groups per line.
   always_comb begin
      if (gpl_ff == 5'd0) begin
         limit = b64le_pkg::MIN_GROUPS;
      end else if (gpl_ff > b64le_pkg::MAX_GROUPS) begin
         limit = b64le_pkg::MAX_GROUPS;
      end else begin
         limit = gpl_ff;
      end
   end

   // A beat closes a group when it completes three bytes or ends the buffer.
   assign closes    = req_data.last_byte || (fill_ff == 2'd2);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign push_valid = req_valid && closes;
   assign done      = line_done_ff + 5'd1;

   // Build the job for a closing beat.
   always_comb begin
      case (fill_ff)
         2'd0: begin
            push_job.bits = {req_data.data_byte, 16'h0000};
         end
         2'd1: begin
            push_job.bits = {held_ff[15:8], req_data.data_byte, 8'h00};
         end
         default: begin
            push_job.bits = {held_ff, req_data.data_byte};
         end
      endcase
      push_job.fill    = fill_ff;
      push_job.newline = req_data.last_byte || (done >= limit);
   end

   // Next group and line state.
   always_comb begin
      held_in      = held_ff;
      fill_in      = fill_ff;
      line_done_in = line_done_ff;
      if (accept) begin
         if (closes) begin
            held_in      = 16'h0000;
            fill_in      = 2'd0;
            line_done_in = (push_job.newline) ? 5'd0 : done;
         end else if (fill_ff == 2'd0) begin
            held_in = {req_data.data_byte, 8'h00};
            fill_in = 2'd1;
         end else begin
            held_in = {held_ff[15:8], req_data.data_byte};
            fill_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 16'h0000;
         fill_ff      <= 2'd0;
         line_done_ff <= 5'd0;
         gpl_ff       <= b64le_pkg::MAX_GROUPS;
      end else begin
         held_ff      <= held_in;
         fill_ff      <= fill_in;
         line_done_ff <= line_done_in;
         gpl_ff       <= gpl_in;
      end
   end

endmodule

>>> hw/rtl/b64le_fifo.sv
// Short job queue between the front end and the back end.
module b64le_fifo #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  b64le_pkg::job_type push_job,
   output logic               pop_valid,
   input  logic               pop_ready,
   output b64le_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64le_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and count updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/b64le_back.sv
// Back end: expands each job into base64 characters, one per unstalled cycle, into an output register.
module b64le_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  b64le_pkg::job_type pop_job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64le_pkg::rsp_type rsp_data
);

   // Character positions within a job.
   localparam logic [2:0] POS_C0 = 3'd0;
   localparam logic [2:0] POS_C1 = 3'd1;
   localparam logic [2:0] POS_C2 = 3'd2;
   localparam logic [2:0] POS_C3 = 3'd3;
   localparam logic [2:0] POS_NL = 3'd4;

   b64le_pkg::job_type job_ff, job_in;
   b64le_pkg::rsp_type rsp_ff, rsp_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       emit;
   logic       last_char;
   logic [6:0] code;

   // The output register can take a character when empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && advance;
   assign last_char = (idx_ff == POS_NL) || ((idx_ff == POS_C3) && !job_ff.newline);
   assign pop_ready = !busy_ff || (emit && last_char);

   // Select the character at the current position.
   always_comb begin
      case (idx_ff)
         POS_C0: begin
            code = b64le_pkg::b64_letter(job_ff.bits[23:18]);
         end
         POS_C1: begin
            code = b64le_pkg::b64_letter(job_ff.bits[17:12]);
         end
         POS_C2: begin
            code = (job_ff.fill == 2'd0) ? b64le_pkg::CODE_PAD
                                         : b64le_pkg::b64_letter(job_ff.bits[11:6]);
         end
         POS_C3: begin
            code = (job_ff.fill != 2'd2) ? b64le_pkg::CODE_PAD
                                         : b64le_pkg::b64_letter(job_ff.bits[5:0]);
         end
         default: begin
            code = b64le_pkg::CODE_NEWLINE;
         end
      endcase
   end

   // Sequencer and output register next state.
   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = busy_ff;
      end
      if (emit) begin
         rsp_in.char_code = code;
         rsp_in.run_last  = last_char;
         idx_in           = idx_ff + 3'd1;
         if (last_char) begin
            busy_in = 1'b0;
         end
      end
      if (pop_ready && pop_valid) begin
         job_in  = pop_job;
         busy_in = 1'b1;
         idx_in  = POS_C0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= POS_C0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A newline position is only reached by a job that asks for one.
   a_nl_needs_flag: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (idx_ff == POS_NL)) |-> job_ff.newline)
      else $error("newline position reached without newline flag");

   // The position counter never runs past the newline slot while busy.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= POS_NL))
      else $error("character position out of range");

   // A new job is only taken when the previous one has finished.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (busy_ff && (idx_ff == POS_C0)))
      else $error("job load did not restart the sequencer");

   // Every character emitted sits in the output register on the next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted character missing from output register");

endmodule

>>> hw/rtl/base64_line_encoder.sv
// Top level of the base64 line encoder: front end, job queue and back end.
// Path: the byte that closes a group is written into the job queue; the back end then loads the
// job into its job register and from there writes the first character into the output register.
// Throughput: one character per cycle while the receiver is ready, set by the back end's single
// output register; a byte is taken every cycle while the job queue has room.
// Reset: synchronous, active high; clears group and line state, empties the queue and sets
// the line length to 18 groups.
module base64_line_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b64le_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64le_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_data
);

   logic               push_valid;
   logic               push_ready;
   b64le_pkg::job_type push_job;
   logic               pop_valid;
   logic               pop_ready;
   b64le_pkg::job_type pop_job;

   // Byte intake and grouping.
   b64le_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Job queue.
   b64le_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Character output.
   b64le_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_base64_line_encoder.sv
// Self-checking testbench for the base64 line encoder with line wrap.
`timescale 1ns / 1ps

module tb_base64_line_encoder;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_BYTES = 50;
   localparam int PHASE_COUNT = 5;

   // Tracks the encoder state and holds the characters still owed by the block.
   class encoded_text_board;
      logic [4:0]  line_groups;
      logic [15:0] held_pair;
      logic [1:0]  held_count;
      logic [4:0]  groups_on_line;
      b64le_pkg::rsp_type chars_due[$];
      int          mismatches;
      int          chars_checked;
      int          line_ends;
      string       alphabet;

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         line_groups = b64le_pkg::MAX_GROUPS;
         held_pair = '0;
         held_count = '0;
         groups_on_line = '0;
         mismatches = 0;
         chars_checked = 0;
         line_ends = 0;
      endfunction

      function void set_line_groups(logic [4:0] value);
         line_groups = value;
      endfunction

      function logic [6:0] to_letter(logic [5:0] sextet);
         byte code;
         code = alphabet[sextet];
         return code[6:0];
      endfunction

      function void owe_char(logic [6:0] code, logic closing);
         b64le_pkg::rsp_type c;
         c.char_code = code;
         c.run_last = closing;
         chars_due.push_back(c);
      endfunction

      // Work out the characters that one accepted byte causes.
      function void take_byte(b64le_pkg::req_type beat);
         logic [23:0] group;
         logic [4:0]  limit;
         logic [4:0]  done_now;
         logic        wrap;
         if (!beat.last_byte && held_count < 2'd2) begin
            if (held_count == 2'd0) begin
               held_pair = {beat.data_byte, 8'h00};
            end else begin
               held_pair[7:0] = beat.data_byte;
            end
            held_count = held_count + 2'd1;
            return;
         end
         case (held_count)
            2'd0: group = {beat.data_byte, 16'h0000};
            2'd1: group = {held_pair[15:8], beat.data_byte, 8'h00};
            default: group = {held_pair, beat.data_byte};
         endcase
         // A zero setting means one group; anything past the maximum is clamped.
         if (line_groups == 5'd0) begin
            limit = b64le_pkg::MIN_GROUPS;
         end else if (line_groups > b64le_pkg::MAX_GROUPS) begin
            limit = b64le_pkg::MAX_GROUPS;
         end else begin
            limit = line_groups;
         end
         done_now = groups_on_line + 5'd1;
         wrap = beat.last_byte || (done_now >= limit);
         owe_char(to_letter(group[23:18]), 1'b0);
         owe_char(to_letter(group[17:12]), 1'b0);
         owe_char((held_count >= 2'd1) ? to_letter(group[11:6]) : b64le_pkg::CODE_PAD, 1'b0);
         owe_char((held_count == 2'd2) ? to_letter(group[5:0]) : b64le_pkg::CODE_PAD, !wrap);
         if (wrap) begin
            owe_char(b64le_pkg::CODE_NEWLINE, 1'b1);
            groups_on_line = '0;
         end else begin
            groups_on_line = done_now;
         end
         held_pair = '0;
         held_count = '0;
      endfunction

      // Compare one output beat with the oldest character owed.
      function void match_char(b64le_pkg::rsp_type got);
         b64le_pkg::rsp_type want;
         if (chars_due.size() == 0) begin
            $error("unexpected character: char_code %0d run_last %0d",
                   got.char_code, got.run_last);
            mismatches++;
            return;
         end
         want = chars_due.pop_front();
         chars_checked++;
         if (want.char_code == b64le_pkg::CODE_NEWLINE) begin
            line_ends++;
         end
         if (got.char_code !== want.char_code) begin
            $error("char_code: expected %0d, actual %0d", want.char_code, got.char_code);
            mismatches++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   b64le_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   b64le_pkg::rsp_type rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [4:0]         csr_data;

   encoded_text_board board;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off_wanted;
   int hold_off_left;
   int quiet_cycles;
   int bytes_sent;
   int buffers_closed;

   base64_line_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: check each accepted beat, then choose ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.match_char(rsp_data);
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_wanted) begin
         hold_off_wanted = 1'b0;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one byte, with random idle cycles first, and wait until it is taken.
   task automatic send_byte(input logic [7:0] value, input logic closing);
      b64le_pkg::req_type beat;
      beat.data_byte = value;
      beat.last_byte = closing;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      board.take_byte(beat);
      bytes_sent++;
      if (closing) begin
         buffers_closed++;
      end
   endtask

   // Drop valid in the same step as the last acceptance.
   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Change the line length once the encoder has drained.
   task automatic write_line_groups(input logic [4:0] value);
      while (board.chars_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      board.set_line_groups(value);
   endtask

   // Random buffers: mostly short, some long enough to wrap lines, a few left open.
   task automatic send_random_bytes(input int total);
      int left;
      int length;
      bit closes;
      left = total;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            length = $urandom_range(1, 12);
         end else begin
            length = $urandom_range(13, 80);
         end
         if (length > left) begin
            length = left;
         end
         closes = ($urandom_range(0, 9) != 0);
         for (int i = 0; i < length; i++) begin
            send_byte($urandom_range(0, 255), closes && (i == length - 1));
         end
         left = left - length;
      end
      stop_sending();
   endtask

   initial begin
      logic [4:0] phase_groups [PHASE_COUNT];
      int         phase_idle [PHASE_COUNT];
      int         phase_stall [PHASE_COUNT];
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_wanted = 1'b0;
      hold_off_left = 0;
      quiet_cycles = 0;
      bytes_sent = 0;
      buffers_closed = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset line length, extreme bytes, every padding case.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'h4D, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      // Two groups into a line, then shrink the line below that count.
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h20, 1'b0);
      stop_sending();
      write_line_groups(5'd1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h0F, 1'b0);
      stop_sending();
      // A zero setting behaves as one group per line.
      write_line_groups(5'd0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h7E, 1'b1);
      stop_sending();

      // Random phases, each with its own line length and idling mix.
      phase_groups = '{5'd31, 5'd19, 5'($urandom_range(2, 17)), 5'd1, 5'd18};
      phase_idle = '{0, 51, 0, 38, 0};
      phase_stall = '{0, 0, 51, 38, 0};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_line_groups(phase_groups[p]);
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         // The last phase starts with a long receiver hold-off to back up the input.
         if (p == PHASE_COUNT - 1) begin
            hold_off_wanted = 1'b1;
         end
         send_random_bytes(PHASE_BYTES);
      end

      while (board.chars_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d bytes in %0d closed buffers; %0d characters checked, %0d line ends.",
               bytes_sent, buffers_closed, board.chars_checked, board.line_ends);
      $display("Line lengths 0, 1, 18, 19 and 31 groups, with idle, stall and hold-off phases.");
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
